FILE: rtl/tthd_pkg.sv
// Shared types, codes and sizes for the touch tap / hold / drag gesture block.
// Used by every module of the block and by its port checker; depends on nothing.
`timescale 1ns / 1ps

package tthd_pkg;

	localparam int XW     = 13;         // coordinate and display size width
	localparam int MW     = 16;         // relative motion width
	localparam int TW     = 32;         // timestamp width
	localparam int DSQ_W  = 2 * XW + 1; // sum of two squared coordinate deltas
	localparam int SLSQ_W = 16;         // squared slop radius
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 16;
	localparam int QDEPTH = 4;          // command queue depth, a power of two
	localparam int QAW    = 2;          // command queue pointer width

	// Event kinds.
	localparam logic [1:0] MODE_BUTTON = 2'd0;
	localparam logic [1:0] MODE_MOTION = 2'd1;
	localparam logic [1:0] MODE_CANCEL = 2'd2;

	// Host pointer actions.
	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_POS     = 3'd1;
	localparam logic [2:0] ACT_MOVE    = 3'd2;
	localparam logic [2:0] ACT_PRESS   = 3'd3;
	localparam logic [2:0] ACT_RELEASE = 3'd4;

	localparam logic BTN_LEFT  = 1'b0;
	localparam logic BTN_RIGHT = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_AW-1:0] REG_GESTURE_DISABLED  = 3'd0;
	localparam logic [CFG_AW-1:0] REG_SESSION_STARTED   = 3'd1;
	localparam logic [CFG_AW-1:0] REG_RELATIVE_MOUSE    = 3'd2;
	localparam logic [CFG_AW-1:0] REG_ABSOLUTE_ELIGIBLE = 3'd3;
	localparam logic [CFG_AW-1:0] REG_SCREEN_W          = 3'd4;
	localparam logic [CFG_AW-1:0] REG_SCREEN_H          = 3'd5;
	localparam logic [CFG_AW-1:0] REG_LONG_PRESS_MS     = 3'd6;
	localparam logic [CFG_AW-1:0] REG_DRAG_SLOP_PX      = 3'd7;

	localparam logic [XW-1:0] RST_SCREEN_W      = 13'd1920;
	localparam logic [XW-1:0] RST_SCREEN_H      = 13'd1080;
	localparam logic [15:0]   RST_LONG_PRESS_MS = 16'd1000;
	localparam logic [7:0]    RST_DRAG_SLOP_PX  = 8'd10;

	// Commands from the classifier to the result sequencer.
	localparam logic [2:0] CMD_NONE        = 3'd0; // one empty word
	localparam logic [2:0] CMD_REL_L       = 3'd1; // left release
	localparam logic [2:0] CMD_POS         = 3'd2; // position
	localparam logic [2:0] CMD_POS_REL_L   = 3'd3; // position, left release
	localparam logic [2:0] CMD_POS_CLICK_R = 3'd4; // position, right press, right release
	localparam logic [2:0] CMD_POS_CLICK_L = 3'd5; // position, left press, left release
	localparam logic [2:0] CMD_POS_PRESS_L = 3'd6; // position, left press
	localparam logic [2:0] CMD_MOVE        = 3'd7; // relative move

	typedef struct packed {
		logic [1:0]           mode;
		logic                 is_left_button;
		logic                 pressed;
		logic                 from_touch;
		logic [XW-1:0]        pos_x;
		logic [XW-1:0]        pos_y;
		logic signed [MW-1:0] rel_x;
		logic signed [MW-1:0] rel_y;
		logic [TW-1:0]        time_ms;
	} evt_t;

	typedef struct packed {
		logic [2:0]           action;
		logic                 which_button;
		logic [XW-1:0]        out_x;
		logic [XW-1:0]        out_y;
		logic [XW-1:0]        ref_width;
		logic [XW-1:0]        ref_height;
		logic signed [MW-1:0] move_x;
		logic signed [MW-1:0] move_y;
		logic                 handled;
		logic                 last;
	} act_t;

	typedef struct packed {
		logic          gesture_disabled;
		logic          session_started;
		logic          relative_mouse;
		logic          absolute_eligible;
		logic [XW-1:0] screen_w;
		logic [XW-1:0] screen_h;
		logic [15:0]   long_press_ms;
		logic [7:0]    drag_slop_px;
	} cfg_t;

	typedef struct packed {
		logic [2:0]           kind;
		logic                 handled;
		logic [XW-1:0]        x;
		logic [XW-1:0]        y;
		logic signed [MW-1:0] rel_x;
		logic signed [MW-1:0] rel_y;
	} cmd_t;

endpackage

FILE: rtl/tthd_front.sv
// Front end: registers each event with its squared drag distance, then
// classifies it against the gesture state and pushes one command. Uses tthd_pkg.
`timescale 1ns / 1ps

module tthd_front import tthd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic evt_valid,
	output logic evt_ready,
	input  evt_t evt,
	output logic push,
	output cmd_t push_cmd,
	input  logic q_full
);

	function automatic logic sets_anchor(evt_t e, cfg_t c);
		return e.mode == MODE_BUTTON && e.is_left_button && e.pressed &&
			!c.gesture_disabled &&
			(e.from_touch || (c.absolute_eligible && !c.relative_mouse));
	endfunction

	logic              v_s1;
	evt_t              evt_s1;
	logic [DSQ_W-1:0]  dsq_s1;
	logic [SLSQ_W-1:0] slop_sq_s1;

	logic          active_q, drag_q, lheld_q;
	logic [TW-1:0] stamp_q;
	logic [XW-1:0] anchor_x_q, anchor_y_q;

	logic          active_n, drag_n, lheld_n, set_anchor;
	logic [TW-1:0] stamp_n, held;
	logic [XW-1:0] ax_fwd, ay_fwd;
	logic signed [XW:0]       dx, dy;
	logic signed [2*XW+1:0]   px, py;
	logic [DSQ_W-1:0]  dsq_next;
	logic [SLSQ_W-1:0] slop_sq_next;
	logic [2:0]        cancel_kind;
	logic              eligible;

	assign evt_ready = !v_s1 || !q_full;
	assign push      = v_s1 && !q_full;

	// A press still in stage one owns the anchor the new event is measured from.
	always_comb begin
		if (v_s1 && sets_anchor(evt_s1, cfg)) begin
			ax_fwd = evt_s1.pos_x;
			ay_fwd = evt_s1.pos_y;
		end else begin
			ax_fwd = anchor_x_q;
			ay_fwd = anchor_y_q;
		end
		dx = $signed({1'b0, evt.pos_x}) - $signed({1'b0, ax_fwd});
		dy = $signed({1'b0, evt.pos_y}) - $signed({1'b0, ay_fwd});
		px = dx * dx;
		py = dy * dy;
		dsq_next = {1'b0, px[2*XW-1:0]} + {1'b0, py[2*XW-1:0]};
		slop_sq_next = SLSQ_W'(cfg.drag_slop_px) * SLSQ_W'(cfg.drag_slop_px);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (evt_ready) begin
			v_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready) begin
			evt_s1     <= evt;
			dsq_s1     <= dsq_next;
			slop_sq_s1 <= slop_sq_next;
		end
	end

	assign held     = evt_s1.time_ms - stamp_q;
	assign eligible = evt_s1.from_touch || (cfg.absolute_eligible && !cfg.relative_mouse);
	assign cancel_kind = (cfg.session_started && lheld_q) ? CMD_REL_L : CMD_NONE;

	always_comb begin
		push_cmd         = '0;
		push_cmd.kind    = CMD_NONE;
		push_cmd.x       = evt_s1.pos_x;
		push_cmd.y       = evt_s1.pos_y;
		push_cmd.rel_x   = evt_s1.rel_x;
		push_cmd.rel_y   = evt_s1.rel_y;
		active_n   = active_q;
		drag_n     = drag_q;
		lheld_n    = lheld_q;
		stamp_n    = stamp_q;
		set_anchor = 1'b0;
		unique case (evt_s1.mode)
			MODE_BUTTON: begin
				priority if (cfg.gesture_disabled) begin
					push_cmd.kind = CMD_NONE;
				end else if (!evt_s1.is_left_button || !eligible) begin
					// A right press, or a left event from an ineligible source, cancels a live gesture.
					if (active_q && (evt_s1.pressed || evt_s1.is_left_button)) begin
						push_cmd.kind = cancel_kind;
						active_n = 1'b0;
						drag_n   = 1'b0;
						lheld_n  = 1'b0;
						stamp_n  = '0;
					end
				end else if (evt_s1.pressed) begin
					push_cmd.handled = 1'b1;
					active_n   = 1'b1;
					drag_n     = 1'b0;
					lheld_n    = 1'b0;
					stamp_n    = evt_s1.time_ms;
					set_anchor = 1'b1;
				end else if (active_q) begin
					push_cmd.handled = 1'b1;
					if (drag_q) begin
						push_cmd.kind = lheld_q ? CMD_POS_REL_L : CMD_POS;
					end else if (held >= {16'd0, cfg.long_press_ms}) begin
						push_cmd.kind = CMD_POS_CLICK_R;
					end else begin
						push_cmd.kind = CMD_POS_CLICK_L;
					end
					active_n = 1'b0;
					drag_n   = 1'b0;
					lheld_n  = 1'b0;
					stamp_n  = '0;
				end
			end
			MODE_MOTION: begin
				if (active_q && !cfg.gesture_disabled) begin
					if (drag_q) begin
						push_cmd.handled = 1'b1;
						push_cmd.kind = (cfg.relative_mouse && !evt_s1.from_touch) ?
							CMD_MOVE : CMD_POS;
					end else if (dsq_s1 >= {{(DSQ_W-SLSQ_W){1'b0}}, slop_sq_s1}) begin
						push_cmd.handled = 1'b1;
						push_cmd.kind = CMD_POS_PRESS_L;
						drag_n  = 1'b1;
						lheld_n = 1'b1;
					end
				end
			end
			MODE_CANCEL: begin
				push_cmd.kind = cancel_kind;
				active_n = 1'b0;
				drag_n   = 1'b0;
				lheld_n  = 1'b0;
				stamp_n  = '0;
			end
			default: begin
				push_cmd.kind = CMD_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			drag_q     <= 1'b0;
			lheld_q    <= 1'b0;
			stamp_q    <= '0;
			anchor_x_q <= '0;
			anchor_y_q <= '0;
		end else if (push) begin
			active_q <= active_n;
			drag_q   <= drag_n;
			lheld_q  <= lheld_n;
			stamp_q  <= stamp_n;
			if (set_anchor) begin
				anchor_x_q <= evt_s1.pos_x;
				anchor_y_q <= evt_s1.pos_y;
			end
		end
	end

endmodule

FILE: rtl/tthd_queue.sv
// Short first-word-fall-through command queue between classifier and sequencer.
// Uses tthd_pkg for the command type and depth.
`timescale 1ns / 1ps

module tthd_queue import tthd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	cmd_t             mem_q [QDEPTH];
	logic [QAW-1:0]   wr_q, rd_q;
	logic [QAW:0]     cnt_q;

	assign full  = cnt_q == (QAW+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/tthd_back.sv
// Back end: expands the command at the queue head into one to three result
// words, one per cycle while the act side accepts them, into an output register. Uses tthd_pkg.
`timescale 1ns / 1ps

module tthd_back import tthd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic q_empty,
	input  cmd_t head,
	output logic pop,
	output logic act_valid,
	input  logic act_ready,
	output act_t act
);

	logic [1:0] step_q;
	logic       act_valid_q;
	act_t       act_q;
	act_t       w;
	logic       load, fire;

	always_comb begin
		w = '0;
		w.action = ACT_NONE;
		w.last   = 1'b1;
		unique case (head.kind)
			CMD_NONE:  w.action = ACT_NONE;
			CMD_REL_L: w.action = ACT_RELEASE;
			CMD_POS:   w.action = ACT_POS;
			CMD_MOVE:  w.action = ACT_MOVE;
			CMD_POS_REL_L, CMD_POS_PRESS_L: begin
				w.action = (step_q == 2'd0) ? ACT_POS :
					(head.kind == CMD_POS_REL_L) ? ACT_RELEASE : ACT_PRESS;
				w.last = step_q != 2'd0;
			end
			CMD_POS_CLICK_R, CMD_POS_CLICK_L: begin
				priority if (step_q == 2'd0) begin
					w.action = ACT_POS;
					w.last   = 1'b0;
				end else if (step_q == 2'd1) begin
					w.action = ACT_PRESS;
					w.last   = 1'b0;
				end else begin
					w.action = ACT_RELEASE;
				end
				w.which_button = (step_q != 2'd0 && head.kind == CMD_POS_CLICK_R) ?
					BTN_RIGHT : BTN_LEFT;
			end
			default: w.action = ACT_NONE;
		endcase
		if (w.action == ACT_POS) begin
			w.out_x      = head.x;
			w.out_y      = head.y;
			w.ref_width  = cfg.screen_w;
			w.ref_height = cfg.screen_h;
		end
		if (w.action == ACT_MOVE) begin
			w.move_x = head.rel_x;
			w.move_y = head.rel_y;
		end
		w.handled = w.last && head.handled;
	end

	assign load = !act_valid_q || act_ready;
	assign fire = load && !q_empty;
	assign pop  = fire && w.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (load) begin
				act_valid_q <= !q_empty;
			end
			if (fire) begin
				step_q <= w.last ? 2'd0 : step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			act_q <= w;
		end
	end

	assign act_valid = act_valid_q;
	assign act       = act_q;

endmodule

FILE: rtl/touch_tap_hold_drag_gesture.sv
// Top level of the touch tap / hold / drag gesture recognizer: configuration
// registers, classifier front end, command queue and result sequencer. Uses tthd_pkg.
`timescale 1ns / 1ps

// The block turns pointer button, motion and cancel events into host pointer
// actions: taps become left clicks, holds of at least long_press_ms become
// right clicks, and motion reaching the slop radius becomes a drag. Each event
// word taken on the evt channel yields one to three action words on the act
// channel, in order; the final word of an event has last set and carries the
// handled flag, which is zero on earlier words. An event that causes nothing
// still yields one word with action none. Events are taken one per cycle while
// the command queue has room: the front end registers an event with its
// squared distance to the press point, classifies it from that register and
// writes one command into a four-entry queue. The sequencer drains that queue
// at one action word per cycle while the act side takes them, so a click holds
// its entry for three words and a drag start for two, and a steady stream of
// clicks is limited by that single output port. The first action word of an
// event passes through the event register, a queue entry and the output
// register before it is presented. The act output is a register, so the evt
// side keeps flowing while a finished word waits to be taken, until the queue
// fills. Configuration is written through cfg_we, cfg_addr and cfg_wdata with
// no read-back, and must be written only while no event is in flight.

module touch_tap_hold_drag_gesture import tthd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata,
	input  logic              evt_valid,
	output logic              evt_ready,
	input  evt_t              evt,
	output logic              act_valid,
	input  logic              act_ready,
	output act_t              act
);

	cfg_t cfg_q;
	logic push, pop, q_full, q_empty;
	cmd_t push_cmd, head;

	// Configuration registers; every index of the port maps to one of them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gesture_disabled  <= 1'b0;
			cfg_q.session_started   <= 1'b0;
			cfg_q.relative_mouse    <= 1'b0;
			cfg_q.absolute_eligible <= 1'b0;
			cfg_q.screen_w          <= RST_SCREEN_W;
			cfg_q.screen_h          <= RST_SCREEN_H;
			cfg_q.long_press_ms     <= RST_LONG_PRESS_MS;
			cfg_q.drag_slop_px      <= RST_DRAG_SLOP_PX;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_GESTURE_DISABLED:  cfg_q.gesture_disabled  <= cfg_wdata[0];
				REG_SESSION_STARTED:   cfg_q.session_started   <= cfg_wdata[0];
				REG_RELATIVE_MOUSE:    cfg_q.relative_mouse    <= cfg_wdata[0];
				REG_ABSOLUTE_ELIGIBLE: cfg_q.absolute_eligible <= cfg_wdata[0];
				REG_SCREEN_W:          cfg_q.screen_w          <= cfg_wdata[XW-1:0];
				REG_SCREEN_H:          cfg_q.screen_h          <= cfg_wdata[XW-1:0];
				REG_LONG_PRESS_MS:     cfg_q.long_press_ms     <= cfg_wdata[15:0];
				REG_DRAG_SLOP_PX:      cfg_q.drag_slop_px      <= cfg_wdata[7:0];
			endcase
		end
	end

	// The front end owns the gesture state and decides what each event means.
	tthd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.push      (push),
		.push_cmd  (push_cmd),
		.q_full    (q_full)
	);

	// The queue lets the classifier run ahead while multi-word results drain.
	tthd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	// The back end spells each command out as action words.
	tthd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.act_valid (act_valid),
		.act_ready (act_ready),
		.act       (act)
	);

endmodule

FILE: rtl/tthd_checker.sv
// Port-level checker for the gesture block and the bind that attaches it.
// Uses tthd_pkg; sees only the act channel of touch_tap_hold_drag_gesture.
`timescale 1ns / 1ps

module tthd_checker import tthd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic act_valid,
	input logic act_ready,
	input act_t act
);

	// A stalled action word holds.
	a_act_hold: assert property (@(posedge clk) disable iff (!arst_n)
		act_valid && !act_ready |=> act_valid && $stable(act))
		else $error("act word changed while stalled");

	// Only the final word of an event may carry the handled flag.
	a_handled_last: assert property (@(posedge clk) disable iff (!arst_n)
		act_valid && !act.last |-> !act.handled)
		else $error("handled set on a non-final word");

	// Display size travels with positions only.
	a_ref_pos_only: assert property (@(posedge clk) disable iff (!arst_n)
		act_valid && act.action != ACT_POS |->
			act.ref_width == '0 && act.ref_height == '0 &&
			act.out_x == '0 && act.out_y == '0)
		else $error("position fields set on a non-position word");

	// A button code appears only on press and release words.
	a_button_only: assert property (@(posedge clk) disable iff (!arst_n)
		act_valid && act.action != ACT_PRESS && act.action != ACT_RELEASE |->
			act.which_button == BTN_LEFT)
		else $error("button set on a non-button word");

	// A right press is never the final word of an event.
	a_right_pair: assert property (@(posedge clk) disable iff (!arst_n)
		act_valid && act.action == ACT_PRESS && act.which_button == BTN_RIGHT |->
			!act.last)
		else $error("right press ended an event");

endmodule

bind touch_tap_hold_drag_gesture tthd_checker u_tthd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.act_valid (act_valid),
	.act_ready (act_ready),
	.act       (act)
);

FILE: verif/tthd_action_checker.sv
// Port checker for the touch tap / hold / drag gesture block: it watches the
// config, event and action ports, predicts each action word and compares it.
// Depends on tthd_pkg for the word types, codes and register indexes.
`timescale 1ns / 1ps

module tthd_action_checker import tthd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata,
	input  logic              evt_valid,
	input  logic              evt_ready,
	input  evt_t              evt,
	input  logic              act_valid,
	input  logic              act_ready,
	input  act_t              act,
	output int                mismatches,
	output int                words_due
);

	cfg_t          regs;
	logic          gest_on;
	logic          dragging;
	logic          left_down;
	logic [TW-1:0] press_ms;
	logic [XW-1:0] press_x;
	logic [XW-1:0] press_y;
	act_t          due_q[$];
	int            bad;

	function automatic act_t action_word(input logic [2:0] kind, input logic btn,
			input logic [XW-1:0] x, input logic [XW-1:0] y,
			input logic signed [MW-1:0] mx, input logic signed [MW-1:0] my);
		act_t w;
		w = '0;
		w.action       = kind;
		w.which_button = btn;
		w.out_x        = x;
		w.out_y        = y;
		w.ref_width    = (kind == ACT_POS) ? regs.screen_w : '0;
		w.ref_height   = (kind == ACT_POS) ? regs.screen_h : '0;
		w.move_x       = mx;
		w.move_y       = my;
		return w;
	endfunction

	function automatic string show(input act_t w);
		return $sformatf("act=%0d btn=%0d x=%0d y=%0d w=%0d h=%0d mx=%0d my=%0d hd=%0b last=%0b",
			w.action, w.which_button, w.out_x, w.out_y, w.ref_width, w.ref_height,
			w.move_x, w.move_y, w.handled, w.last);
	endfunction

	task automatic clear_gesture();
		gest_on   = 1'b0;
		dragging  = 1'b0;
		left_down = 1'b0;
		press_ms  = '0;
	endtask

	// A cancel lets go of the left button only once the stream is running.
	task automatic cancel_gesture();
		if (regs.session_started && left_down)
			due_q.push_back(action_word(ACT_RELEASE, BTN_LEFT, '0, '0, '0, '0));
		clear_gesture();
		press_x = '0;
		press_y = '0;
	endtask

	task automatic predict_words(input evt_t e);
		int            first;
		int            dx;
		int            dy;
		int            reach;
		logic          hd;
		logic [TW-1:0] held;
		act_t          w;
		first = due_q.size();
		hd = 1'b0;
		case (e.mode)
			MODE_BUTTON: begin
				if (regs.gesture_disabled) begin
				end else if (!e.is_left_button) begin
					if (e.pressed && gest_on)
						cancel_gesture();
				end else if (!(e.from_touch || (regs.absolute_eligible && !regs.relative_mouse))) begin
					if (gest_on)
						cancel_gesture();
				end else if (e.pressed) begin
					gest_on   = 1'b1;
					dragging  = 1'b0;
					left_down = 1'b0;
					press_ms  = e.time_ms;
					press_x   = e.pos_x;
					press_y   = e.pos_y;
					hd = 1'b1;
				end else if (gest_on) begin
					// Hold time wraps with the timestamp.
					held = e.time_ms - press_ms;
					due_q.push_back(action_word(ACT_POS, BTN_LEFT, e.pos_x, e.pos_y, '0, '0));
					if (dragging) begin
						if (left_down)
							due_q.push_back(action_word(ACT_RELEASE, BTN_LEFT, '0, '0, '0, '0));
					end else if (held >= regs.long_press_ms) begin
						due_q.push_back(action_word(ACT_PRESS, BTN_RIGHT, '0, '0, '0, '0));
						due_q.push_back(action_word(ACT_RELEASE, BTN_RIGHT, '0, '0, '0, '0));
					end else begin
						due_q.push_back(action_word(ACT_PRESS, BTN_LEFT, '0, '0, '0, '0));
						due_q.push_back(action_word(ACT_RELEASE, BTN_LEFT, '0, '0, '0, '0));
					end
					clear_gesture();
					hd = 1'b1;
				end
			end
			MODE_MOTION: begin
				if (gest_on && !regs.gesture_disabled) begin
					if (!dragging) begin
						dx = int'(e.pos_x) - int'(press_x);
						dy = int'(e.pos_y) - int'(press_y);
						reach = int'(regs.drag_slop_px);
						if (dx * dx + dy * dy >= reach * reach) begin
							dragging  = 1'b1;
							left_down = 1'b1;
							due_q.push_back(action_word(ACT_POS, BTN_LEFT, e.pos_x, e.pos_y, '0, '0));
							due_q.push_back(action_word(ACT_PRESS, BTN_LEFT, '0, '0, '0, '0));
							hd = 1'b1;
						end
					end else begin
						if (regs.relative_mouse && !e.from_touch)
							due_q.push_back(action_word(ACT_MOVE, BTN_LEFT, '0, '0, e.rel_x, e.rel_y));
						else
							due_q.push_back(action_word(ACT_POS, BTN_LEFT, e.pos_x, e.pos_y, '0, '0));
						hd = 1'b1;
					end
				end
			end
			MODE_CANCEL: cancel_gesture();
			default: begin
			end
		endcase
		if (due_q.size() == first)
			due_q.push_back(action_word(ACT_NONE, BTN_LEFT, '0, '0, '0, '0));
		w = due_q.pop_back();
		w.handled = hd;
		w.last = 1'b1;
		due_q.push_back(w);
	endtask

	always @(posedge clk or negedge arst_n) begin
		act_t want;
		if (!arst_n) begin
			regs = '0;
			regs.screen_w      = RST_SCREEN_W;
			regs.screen_h      = RST_SCREEN_H;
			regs.long_press_ms = RST_LONG_PRESS_MS;
			regs.drag_slop_px  = RST_DRAG_SLOP_PX;
			clear_gesture();
			press_x = '0;
			press_y = '0;
			due_q.delete();
			bad = 0;
			mismatches <= 0;
			words_due <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_GESTURE_DISABLED:  regs.gesture_disabled  = cfg_wdata[0];
					REG_SESSION_STARTED:   regs.session_started   = cfg_wdata[0];
					REG_RELATIVE_MOUSE:    regs.relative_mouse    = cfg_wdata[0];
					REG_ABSOLUTE_ELIGIBLE: regs.absolute_eligible = cfg_wdata[0];
					REG_SCREEN_W:          regs.screen_w          = cfg_wdata[XW-1:0];
					REG_SCREEN_H:          regs.screen_h          = cfg_wdata[XW-1:0];
					REG_LONG_PRESS_MS:     regs.long_press_ms     = cfg_wdata[15:0];
					REG_DRAG_SLOP_PX:      regs.drag_slop_px      = cfg_wdata[7:0];
					default: begin
					end
				endcase
			end
			if (evt_valid && evt_ready)
				predict_words(evt);
			if (act_valid && act_ready) begin
				if (due_q.size() == 0) begin
					bad++;
					if (bad <= 10)
						$display("%t action word with nothing owed: %s", $realtime, show(act));
				end else begin
					want = due_q.pop_front();
					if (act.action !== want.action || act.which_button !== want.which_button ||
							act.out_x !== want.out_x || act.out_y !== want.out_y ||
							act.ref_width !== want.ref_width || act.ref_height !== want.ref_height ||
							act.move_x !== want.move_x || act.move_y !== want.move_y ||
							act.handled !== want.handled || act.last !== want.last) begin
						bad++;
						if (bad <= 10) begin
							$display("%t action word mismatch", $realtime);
							$display("  expected %s", show(want));
							$display("  actual   %s", show(act));
						end
					end
				end
			end
			mismatches <= bad;
			words_due <= due_q.size();
		end
	end

endmodule

FILE: verif/touch_tap_hold_drag_gesture_test.sv
// Testbench top for the touch tap / hold / drag gesture block: clock, reset,
// register setup, event stimulus, act-side stalls, watchdog and verdict.
// Depends on tthd_pkg, the block itself and tthd_action_checker.
`timescale 1ns / 1ps

module touch_tap_hold_drag_gesture_test;
	import tthd_pkg::*;

	// Mode value 3 has no meaning; the block must answer it with an empty word.
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	// Idle cycles tolerated with no word moving on either side. The longest
	// quiet stretch in a correct run is a sender gap, a pause or a register
	// setup, so this limit is many times over.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES = 8;
	localparam int WORDS_PER_PHASE = 50;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_AW-1:0] cfg_addr;
	logic [CFG_DW-1:0] cfg_wdata;
	logic              evt_valid;
	logic              evt_ready;
	evt_t              evt;
	logic              act_valid;
	logic              act_ready;
	act_t              act;
	int                mismatches;
	int                words_due;

	// The register values in force, kept only to shape the stimulus.
	cfg_t cur;
	int   burst_left = 0;
	int   words_sent = 0;
	int   idle_cycles = 0;
	int   ready_style = 0;
	int   style_left = 0;
	int   run_left = 0;

	touch_tap_hold_drag_gesture dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.act_valid (act_valid),
		.act_ready (act_ready),
		.act       (act)
	);

	tthd_action_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.evt_valid  (evt_valid),
		.evt_ready  (evt_ready),
		.evt        (evt),
		.act_valid  (act_valid),
		.act_ready  (act_ready),
		.act        (act),
		.mismatches (mismatches),
		.words_due  (words_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic evt_t mk_evt(input logic [1:0] mode, input int is_left,
			input int pressed, input int touch, input int x,
			input int y, input int rx, input int ry,
			input logic [TW-1:0] t);
		evt_t e;
		e.mode           = mode;
		e.is_left_button = is_left[0];
		e.pressed        = pressed[0];
		e.from_touch     = touch[0];
		e.pos_x          = x[XW-1:0];
		e.pos_y          = y[XW-1:0];
		e.rel_x          = rx[MW-1:0];
		e.rel_y          = ry[MW-1:0];
		e.time_ms        = t;
		return e;
	endfunction

	// Picks a register value, favoring both extremes and the reset value.
	function automatic int pick_value(input int lo, input int hi, input int usual,
			input int spread);
		case ($urandom_range(0, 4))
			0: return lo;
			1: return hi;
			2: return usual;
			default: return $urandom_range(lo, spread);
		endcase
	endfunction

	// The sender runs in bursts with random gaps, and now and then holds back
	// entirely until the block has delivered every word it owes. Valid stays
	// high from one word to the next inside a burst.
	task automatic send_word(input evt_t e);
		if ($urandom_range(0, 39) == 0) begin
			evt_valid <= 1'b0;
			@(posedge clk);
			while (words_due != 0)
				@(posedge clk);
		end
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
			evt_valid <= 1'b0;
			repeat ($urandom_range(1, 12))
				@(posedge clk);
		end
		burst_left--;
		evt <= e;
		evt_valid <= 1'b1;
		@(posedge clk);
		while (!evt_ready)
			@(posedge clk);
		words_sent++;
	endtask

	// Stops the sender and waits until every owed action word has arrived,
	// then lets the pipeline settle.
	task automatic drain();
		evt_valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	// Register writes carry random junk above each register's width; the
	// block has to ignore it.
	task automatic put_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] v,
			input int w);
		logic [CFG_DW-1:0] word;
		word = CFG_DW'($urandom);
		for (int b = 0; b < w; b++)
			word[b] = v[b];
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= word;
		@(posedge clk);
	endtask

	task automatic program_regs(input cfg_t c);
		put_reg(REG_GESTURE_DISABLED, CFG_DW'(c.gesture_disabled), 1);
		put_reg(REG_SESSION_STARTED, CFG_DW'(c.session_started), 1);
		put_reg(REG_RELATIVE_MOUSE, CFG_DW'(c.relative_mouse), 1);
		put_reg(REG_ABSOLUTE_ELIGIBLE, CFG_DW'(c.absolute_eligible), 1);
		put_reg(REG_SCREEN_W, CFG_DW'(c.screen_w), XW);
		put_reg(REG_SCREEN_H, CFG_DW'(c.screen_h), XW);
		put_reg(REG_LONG_PRESS_MS, c.long_press_ms, 16);
		put_reg(REG_DRAG_SLOP_PX, CFG_DW'(c.drag_slop_px), 8);
		cfg_we <= 1'b0;
		cur = c;
	endtask

	// The act side switches between stall styles at random: always
	// ready, coin flips, mostly ready, or alternating runs.
	always @(posedge clk) begin
		if (style_left == 0) begin
			ready_style <= $urandom_range(0, 3);
			style_left <= $urandom_range(20, 120);
		end else begin
			style_left <= style_left - 1;
		end
		case (ready_style)
			0: act_ready <= 1'b1;
			1: act_ready <= 1'($urandom_range(0, 1));
			2: act_ready <= ($urandom_range(0, 3) != 0);
			default: begin
				if (run_left == 0) begin
					act_ready <= ~act_ready;
					run_left <= $urandom_range(1, 10);
				end else begin
					run_left <= run_left - 1;
				end
			end
		endcase
	end

	// A hang on either side shows up as a long stretch with no word moving.
	always @(posedge clk) begin
		if ((evt_valid && evt_ready) || (act_valid && act_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("touch_tap_hold_drag_gesture_test: FAIL");
			$finish;
		end
	end

	initial begin
		cfg_t          c;
		int            ax;
		int            ay;
		int            px;
		int            py;
		int            r;
		int            nmov;
		int            ending;
		int            target;
		logic [TW-1:0] held;
		logic [TW-1:0] t0;
		int            tch;
		logic [127:0]  raw;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_addr <= '0;
		cfg_wdata <= '0;
		evt_valid <= 1'b0;
		evt <= '0;
		act_ready <= 1'b0;
		cur = '0;
		cur.screen_w      = RST_SCREEN_W;
		cur.screen_h      = RST_SCREEN_H;
		cur.long_press_ms = RST_LONG_PRESS_MS;
		cur.drag_slop_px  = RST_DRAG_SLOP_PX;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset register values. A short tap gives a
		// left click; a hold of exactly the long-press time, across the
		// timestamp wrap, gives a right click.
		send_word(mk_evt(MODE_BUTTON, 1, 1, 1, 100, 200, 0, 0, 32'd1000));
		send_word(mk_evt(MODE_BUTTON, 1, 0, 1, 101, 199, 0, 0, 32'd1999));
		send_word(mk_evt(MODE_BUTTON, 1, 1, 1, 0, 0, 0, 0, 32'hFFFF_FE00));
		send_word(mk_evt(MODE_BUTTON, 1, 0, 1, 0, 0, 0, 0, 32'h0000_01E8));
		// Press in the far corner; motion just inside the slop radius does
		// nothing, motion exactly on it starts a drag, release ends it.
		send_word(mk_evt(MODE_BUTTON, 1, 1, 1, 8191, 8191, 0, 0, 32'd7));
		send_word(mk_evt(MODE_MOTION, 0, 0, 1, 8191, 8182, 0, 0, 32'd8));
		send_word(mk_evt(MODE_MOTION, 0, 0, 1, 8185, 8183, 0, 0, 32'd9));
		send_word(mk_evt(MODE_MOTION, 0, 0, 1, 4000, 3000, 0, 0, 32'd10));
		send_word(mk_evt(MODE_BUTTON, 1, 0, 1, 8191, 0, 0, 0, 32'd11));
		// With no gesture open, motion and release are not consumed.
		send_word(mk_evt(MODE_MOTION, 0, 0, 1, 5, 5, 0, 0, 32'd12));
		send_word(mk_evt(MODE_BUTTON, 1, 0, 1, 5, 5, 0, 0, 32'd13));
		// A mouse press is not eligible until absolute_eligible is set.
		send_word(mk_evt(MODE_BUTTON, 1, 1, 0, 5, 5, 0, 0, 32'd14));
		// A right press cancels an open gesture with only an empty word sent.
		send_word(mk_evt(MODE_BUTTON, 1, 1, 1, 50, 50, 0, 0, 32'd15));
		send_word(mk_evt(MODE_BUTTON, 0, 1, 1, 50, 50, 0, 0, 32'd16));
		send_word(mk_evt(MODE_UNUSED, 1, 1, 1, 8191, 8191, 'hFFFF, 'hFFFF, 32'hFFFF_FFFF));
		send_word(mk_evt(MODE_CANCEL, 0, 0, 0, 0, 0, 0, 0, 32'd17));
		drain();

		// Running session in relative mode, zero display width, widest slop and
		// longest hold time.
		c = '0;
		c.session_started   = 1'b1;
		c.relative_mouse    = 1'b1;
		c.absolute_eligible = 1'b1;
		c.screen_w          = '0;
		c.screen_h          = 13'd8191;
		c.long_press_ms     = 16'hFFFF;
		c.drag_slop_px      = 8'hFF;
		program_regs(c);
		send_word(mk_evt(MODE_BUTTON, 1, 1, 0, 9, 9, 0, 0, 32'd0));
		send_word(mk_evt(MODE_BUTTON, 1, 1, 1, 0, 0, 0, 0, 32'd0));
		send_word(mk_evt(MODE_MOTION, 0, 0, 1, 180, 180, 0, 0, 32'd1));
		send_word(mk_evt(MODE_MOTION, 0, 0, 0, 255, 0, 0, 0, 32'd2));
		send_word(mk_evt(MODE_MOTION, 0, 0, 0, 3, 3, 'h8000, 'h7FFF, 32'd3));
		send_word(mk_evt(MODE_MOTION, 0, 0, 1, 7, 7, 0, 0, 32'd4));
		// Cancel with the left button held in a running session releases it.
		send_word(mk_evt(MODE_CANCEL, 0, 0, 0, 0, 0, 0, 0, 32'd5));
		send_word(mk_evt(MODE_BUTTON, 1, 1, 1, 10, 10, 0, 0, 32'hFFFF_FFFF));
		send_word(mk_evt(MODE_BUTTON, 1, 0, 1, 10, 10, 0, 0, 32'h0000_FFFD));
		drain();

		// Random phases, each under its own register setting. The first two
		// pin the timing and slop registers to their extremes; phase three always
		// has the gesture logic switched off, and any other phase may at random.
		for (int phase = 0; phase < PHASES; phase++) begin
			c.gesture_disabled  = (phase == 3) || ($urandom_range(0, 7) == 0);
			c.session_started   = 1'($urandom_range(0, 1));
			c.relative_mouse    = 1'($urandom_range(0, 1));
			c.absolute_eligible = 1'($urandom_range(0, 1));
			c.screen_w          = XW'(pick_value(0, 8191, 1920, 8191));
			c.screen_h          = XW'(pick_value(0, 8191, 1080, 8191));
			c.long_press_ms     = 16'(pick_value(0, 65535, 1000, 3000));
			c.drag_slop_px      = 8'(pick_value(0, 255, 10, 40));
			if (phase == 0) begin
				c.long_press_ms = '0;
				c.drag_slop_px  = '0;
			end else if (phase == 1) begin
				c.long_press_ms = 16'hFFFF;
				c.drag_slop_px  = 8'hFF;
				c.screen_w      = 13'd8191;
				c.screen_h      = 13'd8191;
			end
			program_regs(c);

			target = words_sent + WORDS_PER_PHASE;
			while (words_sent < target) begin
				if ($urandom_range(0, 4) == 0) begin
					// Noise: any field value at all, unused mode included.
					raw = {$urandom, $urandom, $urandom, $urandom};
					send_word(raw[$bits(evt_t)-1:0]);
				end else begin
					// A well-formed gesture: press, some motion around the press
					// point, then mostly a release timed near the long-press
					// boundary, sometimes a cancel of one kind or another.
					tch = ($urandom_range(0, 3) != 0) ? 1 : 0;
					ax = $urandom_range(0, 8191);
					ay = $urandom_range(0, 8191);
					t0 = $urandom;
					r = int'(cur.drag_slop_px);
					send_word(mk_evt(MODE_BUTTON, 1, 1, tch, ax, ay, $urandom, $urandom, t0));
					nmov = $urandom_range(0, 4);
					for (int m = 0; m < nmov; m++) begin
						if ($urandom_range(0, 3) == 0) begin
							// Exactly on the slop radius along one axis.
							px = (ax + r <= 8191) ? ax + r : ax - r;
							py = ay;
						end else begin
							px = ax + $urandom_range(0, 2 * r + 4) - (r + 2);
							py = ay + $urandom_range(0, 2 * r + 4) - (r + 2);
							px = (px < 0) ? 0 : (px > 8191) ? 8191 : px;
							py = (py < 0) ? 0 : (py > 8191) ? 8191 : py;
						end
						send_word(mk_evt(MODE_MOTION, $urandom, $urandom, $urandom, px, py,
							$urandom, $urandom, t0 + m + 1));
					end
					case ($urandom_range(0, 3))
						0: held = TW'(cur.long_press_ms) - 1;
						1: held = TW'(cur.long_press_ms);
						2: held = TW'(cur.long_press_ms) + 1;
						default: held = $urandom_range(0, 2 * cur.long_press_ms + 5);
					endcase
					ending = $urandom_range(0, 19);
					if (ending < 14)
						send_word(mk_evt(MODE_BUTTON, 1, 0, tch, $urandom, $urandom,
							$urandom, $urandom, t0 + held));
					else if (ending < 16)
						send_word(mk_evt(MODE_CANCEL, $urandom, $urandom, $urandom, $urandom,
							$urandom, $urandom, $urandom, $urandom));
					else if (ending < 18)
						send_word(mk_evt(MODE_BUTTON, 0, $urandom, $urandom, $urandom,
							$urandom, $urandom, $urandom, t0 + held));
					else if (ending < 19)
						send_word(mk_evt(MODE_BUTTON, 1, $urandom, 0, $urandom, $urandom,
							$urandom, $urandom, t0 + held));
					// Otherwise the gesture is left open for the next one.
				end
			end
			drain();
		end

		repeat (6)
			@(posedge clk);
		if (mismatches == 0 && words_due == 0)
			$display("touch_tap_hold_drag_gesture_test: PASS");
		else
			$display("touch_tap_hold_drag_gesture_test: FAIL");
		$finish;
	end

endmodule

FILE: files.f
rtl/tthd_pkg.sv
rtl/tthd_front.sv
rtl/tthd_queue.sv
rtl/tthd_back.sv
rtl/touch_tap_hold_drag_gesture.sv
rtl/tthd_checker.sv
verif/tthd_action_checker.sv
verif/touch_tap_hold_drag_gesture_test.sv
